// File: src/disjoint_region_table_unit_assert.svh
// assertion macros for the region table
`ifndef DISJOINT_REGION_TABLE_UNIT_ASSERT_SVH
`define DISJOINT_REGION_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DRT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define DRT_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DRT_ASSERT_IMP(label, clk, rst, a, c)
`define DRT_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: src/drt_pkg.sv
// ----------------------------------------------------------------------
// drt_pkg
// types and codes shared by the region table
// ----------------------------------------------------------------------
package drt_pkg;
  localparam int unsigned AddrW = 40;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_ADD_DIRECT = 3'd1, OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3, OP_OVERLAP = 3'd4, OP_PROTECT = 3'd5,
    OP_RSVD6 = 3'd6, OP_RSVD7 = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_WAIT, ST_EVAL, ST_APPEND, ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  prot;
    logic [31:0] sce_prot;
    logic        reserved_flag;
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] phys_offset;
    logic [2:0]  opcode;
  } req_t;

  typedef struct packed {
    logic status;
    logic found;
    logic [AddrW-1:0] region_start;
    logic [AddrW-1:0] region_length;
    logic [3:0] region_prot;
    logic [31:0] region_sce_prot;
    logic region_reserved;
    logic region_has_phys;
    logic [AddrW-1:0] region_phys;
  } rsp_t;
endpackage

// File: src/drt_if.sv
// ----------------------------------------------------------------------
// drt_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------
interface drt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/drt_core.sv
// ----------------------------------------------------------------------
// drt_core
// sequencer walking the entry memory one entry per step
// ----------------------------------------------------------------------
module drt_core #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  drt_pkg::req_t req,
  output logic busy,
  output logic done,
  output drt_pkg::rsp_t rsp
);
  import drt_pkg::*;
  localparam int unsigned ADDR_BITS = AddrW;
  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned EW = ADDR_BITS + 1;
  localparam int unsigned RW = ADDR_BITS*3 + 4 + 32 + 2;

  // entry memory, one packed row per region
  logic [RW-1:0] mem [MAX_REGIONS];
  logic [RW-1:0] rd_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [RW-1:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  logic [CW-1:0] count, idx, src, walk_n;
  logic [2:0] op;
  logic [ADDR_BITS-1:0] p, len, phys_in;
  logic [EW-1:0] r_end;
  logic [3:0] prot_in;
  logic [31:0] sce_in;
  logic resv_in, lost, hit;
  // pending append of a split tail or the new region
  logic [RW-1:0] app_row;
  logic app_pend, app_new;
  rsp_t res;

  // fields of the current row
  logic [ADDR_BITS-1:0] es, el, eph;
  logic [3:0] epr;
  logic [31:0] esp;
  logic [1:0] efl;
  logic [EW-1:0] ee, ee_wide;
  assign {es, el, eph, epr, esp, efl} = rd_data;
  assign ee_wide = {1'b0, es} + {1'b0, el};
  assign ee = ee_wide;

  logic in_range, isect, covers, straddle, is_punch;
  assign isect = ({1'b0, p} < ee) && ({1'b0, es} < r_end);
  assign covers = (es >= p) && (ee <= r_end);
  assign straddle = (es < p) && (ee > r_end);
  assign in_range = ({1'b0, p} >= {1'b0, es}) && ({1'b0, p} < ee);
  assign is_punch = (op == OP_ADD) || (op == OP_ADD_DIRECT) || (op == OP_REMOVE);

  logic [ADDR_BITS-1:0] cut;
  assign cut = r_end[ADDR_BITS-1:0] - es;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_READ;
      ST_READ: state_next = (src < walk_n && !hit) ? ST_WAIT : ST_APPEND;
      ST_WAIT: state_next = ST_EVAL;
      ST_EVAL: state_next = ST_READ;
      ST_APPEND: state_next = (app_pend || app_new) ? ST_APPEND : ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    rsp = res;
    rsp.status = lost;
    rd_addr = src[IW-1:0];
  end

  // write port: compaction, trims and appends
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = rd_data;
    if (state == ST_EVAL && is_punch) begin
      wr_en = 1'b1;
      if (!isect) wr_data = rd_data;
      else if (covers) wr_en = 1'b0;
      else if (straddle) wr_data = {es, p - es, eph, epr, esp, efl};
      else if (es < p) wr_data = {es, p - es, eph, epr, esp, efl};
      else wr_data = {r_end[ADDR_BITS-1:0], ee[ADDR_BITS-1:0] - r_end[ADDR_BITS-1:0],
                      eph + cut, epr, esp, efl};
      if (straddle && count >= CW'(MAX_REGIONS)) wr_data = rd_data;
    end else if (state == ST_EVAL && op == OP_PROTECT) begin
      wr_en = 1'b1;
      wr_addr = src[IW-1:0];
      wr_data = isect ? {es, el, eph, prot_in, sce_in, efl} : rd_data;
    end else if (state == ST_APPEND && (app_pend || app_new)
                 && count < CW'(MAX_REGIONS)) begin
      wr_en = 1'b1;
      wr_addr = count[IW-1:0];
      wr_data = app_pend ? app_row
        : {p, len, (op == OP_ADD_DIRECT) ? phys_in : {ADDR_BITS{1'b0}}, prot_in, sce_in,
           (op == OP_ADD_DIRECT) ? 2'b10 : {1'b0, resv_in}};
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          op <= req.opcode;
          p <= req.addr[ADDR_BITS-1:0];
          // clip so the range ends at or below the top
          if ({1'b0, req.length} > ({1'b0, ~req.addr} + EW'(1))) begin
            len <= ~req.addr + ADDR_BITS'(1);
          end else begin
            len <= req.length;
          end
          r_end <= ({1'b0, req.addr} + {1'b0, req.length} > {1'b1, {ADDR_BITS{1'b0}}})
                   ? {1'b1, {ADDR_BITS{1'b0}}} : {1'b0, req.addr} + {1'b0, req.length};
          prot_in <= req.prot;
          sce_in <= req.sce_prot;
          resv_in <= req.reserved_flag;
          phys_in <= req.phys_offset;
          idx <= '0;
          src <= '0;
          walk_n <= count;
          lost <= 1'b0;
          hit <= 1'b0;
          app_pend <= 1'b0;
          app_new <= (req.opcode == OP_ADD) || (req.opcode == OP_ADD_DIRECT);
          res <= '0;
        end
        ST_EVAL: begin
          src <= src + CW'(1);
          if (is_punch) begin
            if (isect && covers) count <= count - CW'(1);
            else idx <= idx + CW'(1);
            if (isect && straddle) begin
              if (count >= CW'(MAX_REGIONS)) lost <= 1'b1;
              else begin
                app_pend <= 1'b1;
                app_row <= {r_end[ADDR_BITS-1:0], ee[ADDR_BITS-1:0] - r_end[ADDR_BITS-1:0],
                            eph + cut, epr, esp, efl};
              end
            end
          end else if (op == OP_LOOKUP && in_range) begin
            hit <= 1'b1;
            res.found <= 1'b1;
            res.region_start <= es;
            res.region_length <= el;
            res.region_prot <= epr;
            res.region_sce_prot <= esp;
            res.region_reserved <= efl[0];
            res.region_has_phys <= efl[1];
            res.region_phys <= efl[1] ? eph : '0;
          end else if (op == OP_OVERLAP && isect) begin
            hit <= 1'b1;
            res.found <= 1'b1;
          end
        end
        ST_APPEND: begin
          if (app_pend) begin
            app_pend <= 1'b0;
            count <= count + CW'(1);
          end else if (app_new) begin
            app_new <= 1'b0;
            if (count < CW'(MAX_REGIONS)) count <= count + CW'(1);
            else lost <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/disjoint_region_table_unit.sv
// ----------------------------------------------------------------------
// disjoint_region_table_unit
// table of disjoint address regions with punch, lookup and protect
// ----------------------------------------------------------------------
// each item walks the stored entries in order; split tails and new regions are appended at the end
// one item at a time: a new item is taken only while the core is idle and the output register is empty
// the walk reads one entry at a time through the single read port of the entry memory
// reset: synchronous rst empties the table; entry memory itself is not cleared
`include "disjoint_region_table_unit_assert.svh"
module disjoint_region_table_unit #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input logic clk,
  input logic rst,
  drt_if.sink   in_ch,
  drt_if.source out_ch
);
  import drt_pkg::*;
  logic busy, done, start;
  rsp_t rsp;
  logic out_full;

  assign start = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy && !out_full;

  drt_core #(.MAX_REGIONS(MAX_REGIONS)) u_core (
    .clk(clk), .rst(rst), .start(start), .req(in_ch.data),
    .busy(busy), .done(done), .rsp(rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (done) out_full <= 1'b1;
    else if (out_ch.ready) out_full <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_ch.data <= rsp;
    end
  end
  assign out_ch.valid = out_full;

  `DRT_ASSERT_NXT(a_start_busy, clk, rst, start, busy)
  `DRT_ASSERT_IMP(a_no_start_busy, clk, rst, busy, !in_ch.ready)
  `DRT_ASSERT_NXT(a_done_valid, clk, rst, done, out_ch.valid)
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------
// tb
// Checks the region table unit against a behavioral copy of the table.
// Directed items cover add, add direct, remove, lookup, overlap and
// protect with trims, splits, drops, zero lengths, clipping at the top
// of the address space, offset wrap, a full table and unused opcodes;
// random items then work a small address window hard.
// ----------------------------------------------------------------------
module tb;
  import drt_pkg::*;

  localparam int NREG = 64;
  localparam logic [63:0] AMASK = (64'd1 << AddrW) - 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drt_if #(.T(req_t)) req_ch();
  drt_if #(.T(rsp_t)) rsp_ch();

  disjoint_region_table_unit dut (
    .clk(clk), .rst(rst), .in_ch(req_ch), .out_ch(rsp_ch)
  );

  always #5 clk = ~clk;

  // table copy used for prediction
  logic [AddrW-1:0] tbl_start [NREG];
  logic [AddrW-1:0] tbl_len   [NREG];
  logic [AddrW-1:0] tbl_phys  [NREG];
  logic [3:0]       tbl_prot  [NREG];
  logic [31:0]      tbl_sce   [NREG];
  logic [1:0]       tbl_flags [NREG];
  int               tbl_count;

  rsp_t expected_rsp[$];
  int   errors = 0;
  int   cycles = 0;
  int   burst_left = 0;
  int   rx_stall = 0;
  int   rx_mode = 0;

  function automatic bit tbl_append(logic [63:0] s, logic [63:0] l, logic [63:0] ph,
                                    logic [3:0] pr, logic [31:0] sp, logic [1:0] fl);
    if (tbl_count >= NREG) return 1'b0;
    tbl_start[tbl_count] = s[AddrW-1:0];
    tbl_len[tbl_count]   = l[AddrW-1:0];
    tbl_phys[tbl_count]  = ph[AddrW-1:0];
    tbl_prot[tbl_count]  = pr;
    tbl_sce[tbl_count]   = sp;
    tbl_flags[tbl_count] = fl;
    tbl_count++;
    return 1'b1;
  endfunction

  function automatic void tbl_drop(int i);
    for (int j = i; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_len[j]   = tbl_len[j+1];
      tbl_phys[j]  = tbl_phys[j+1];
      tbl_prot[j]  = tbl_prot[j+1];
      tbl_sce[j]   = tbl_sce[j+1];
      tbl_flags[j] = tbl_flags[j+1];
    end
    tbl_count--;
  endfunction

  // cut [p, e) out of the table, returns 1 when a split did not fit
  function automatic bit tbl_punch(logic [63:0] p, logic [63:0] e);
    bit lost;
    int i;
    logic [63:0] es, ee;
    lost = 1'b0;
    i = 0;
    while (i < tbl_count) begin
      es = tbl_start[i];
      ee = es + tbl_len[i];
      if (ee <= p || es >= e) begin
        i++;
      end else if (es >= p && ee <= e) begin
        tbl_drop(i);
      end else if (es < p && ee > e) begin
        if (tbl_count >= NREG) lost = 1'b1;
        else begin
          void'(tbl_append(e, ee - e, (tbl_phys[i] + (e - es)) & AMASK,
                           tbl_prot[i], tbl_sce[i], tbl_flags[i]));
          tbl_len[i] = AddrW'(p - es);
        end
        i++;
      end else if (es < p) begin
        tbl_len[i] = AddrW'(p - es);
        i++;
      end else begin
        tbl_len[i]   = AddrW'(ee - e);
        tbl_phys[i]  = AddrW'(tbl_phys[i] + (e - es));
        tbl_start[i] = AddrW'(e);
        i++;
      end
    end
    return lost;
  endfunction

  function automatic rsp_t region_table_apply(req_t r);
    rsp_t o;
    logic [63:0] a, len, room, e, es, ee;
    bit lost;
    o = '0;
    a = r.addr;
    len = r.length;
    room = AMASK - a;
    if (len > room + 1) len = room + 1;
    e = a + len;
    case (opcode_t'(r.opcode))
      OP_ADD, OP_ADD_DIRECT: begin
        lost = tbl_punch(a, e);
        if (opcode_t'(r.opcode) == OP_ADD) begin
          if (!tbl_append(a, len, 64'd0, r.prot, r.sce_prot, {1'b0, r.reserved_flag}))
            lost = 1'b1;
        end else begin
          if (!tbl_append(a, len, r.phys_offset, r.prot, r.sce_prot, 2'b10))
            lost = 1'b1;
        end
        o.status = lost;
      end
      OP_REMOVE: o.status = tbl_punch(a, e);
      OP_LOOKUP: begin
        for (int i = 0; i < tbl_count; i++) begin
          es = tbl_start[i];
          ee = es + tbl_len[i];
          if (a >= es && a < ee) begin
            o.found = 1'b1;
            o.region_start = tbl_start[i];
            o.region_length = tbl_len[i];
            o.region_prot = tbl_prot[i];
            o.region_sce_prot = tbl_sce[i];
            o.region_reserved = tbl_flags[i][0];
            o.region_has_phys = tbl_flags[i][1];
            o.region_phys = tbl_flags[i][1] ? tbl_phys[i] : '0;
            break;
          end
        end
      end
      OP_OVERLAP: begin
        for (int i = 0; i < tbl_count; i++) begin
          es = tbl_start[i];
          ee = es + tbl_len[i];
          if (a < ee && es < e) begin
            o.found = 1'b1;
            break;
          end
        end
      end
      OP_PROTECT: begin
        for (int i = 0; i < tbl_count; i++) begin
          es = tbl_start[i];
          ee = es + tbl_len[i];
          if (a < ee && es < e) begin
            tbl_prot[i] = r.prot;
            tbl_sce[i] = r.sce_prot;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // send one item, with bursts and gaps
  task automatic send_item(req_t r);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    expected_rsp.push_back(region_table_apply(r));
  endtask

  task automatic send_op(opcode_t op, logic [63:0] a, logic [63:0] len,
                         logic [3:0] pr = 4'h0, logic [31:0] sp = 32'h0,
                         logic rf = 1'b0, logic [63:0] ph = 64'd0);
    req_t r;
    r.opcode = op;
    r.addr = a[AddrW-1:0];
    r.length = len[AddrW-1:0];
    r.prot = pr;
    r.sce_prot = sp;
    r.reserved_flag = rf;
    r.phys_offset = ph[AddrW-1:0];
    send_item(r);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [AddrW-1:0] rand_wide();
    return AddrW'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed_ops();
    send_op(OP_ADD, 64'h1000, 64'h1000, 4'h3, 32'hA5A5_0001, 1'b1);
    send_op(OP_ADD_DIRECT, 64'h3000, 64'h1000, 4'hC, 32'h5A5A_0002, 1'b0, 64'h50000);
    send_op(OP_LOOKUP, 64'h1800, 64'd0);
    send_op(OP_LOOKUP, 64'h3FFF, 64'd0);
    send_op(OP_LOOKUP, 64'h2800, 64'd0);
    send_op(OP_OVERLAP, 64'h2000, 64'h1000);
    send_op(OP_OVERLAP, 64'h1FFF, 64'h2);
    send_op(OP_PROTECT, 64'h1F00, 64'h1200, 4'hF, 32'hFFFF_FFFF);
    // split inside the reserved region, then look at the upper part
    send_op(OP_REMOVE, 64'h1400, 64'h100);
    send_op(OP_LOOKUP, 64'h1600, 64'd0);
    // head trim moves the physical offset, tail trim does not
    send_op(OP_REMOVE, 64'h2F00, 64'h200);
    send_op(OP_LOOKUP, 64'h3200, 64'd0);
    send_op(OP_REMOVE, 64'h3E00, 64'h1000);
    // covering add drops entries
    send_op(OP_ADD, 64'h0, 64'h5000, 4'h1, 32'h0000_0010);
    // zero length add and zero length split
    send_op(OP_ADD, 64'h8000, 64'd0, 4'h2, 32'h1);
    send_op(OP_REMOVE, 64'h2000, 64'd0);
    send_op(OP_LOOKUP, 64'h2000, 64'd0);
    // range past the top is clipped, physical offset wraps
    send_op(OP_ADD_DIRECT, AMASK - 64'hFF, AMASK, 4'h7, 32'h8000_0000, 1'b1, AMASK);
    send_op(OP_REMOVE, AMASK - 64'hFF, 64'h10);
    send_op(OP_LOOKUP, AMASK, 64'd0);
    send_op(OP_OVERLAP, AMASK, AMASK);
    send_op(OP_RSVD6, 64'h1000, 64'h10, 4'hF, 32'hFFFF_FFFF, 1'b1, AMASK);
    send_op(OP_RSVD7, 64'h1000, 64'h10, 4'hF, 32'hFFFF_FFFF, 1'b1, AMASK);
    wait_drain();
  endtask

  task automatic test_table_full();
    send_op(OP_REMOVE, 64'd0, AMASK);
    for (int k = 0; k < NREG + 2; k++)
      send_op(OP_ADD, 64'h10000 + k * 64'h100, 64'h80, 4'(k), 32'(k), 1'(k));
    // split and append with no room left
    send_op(OP_REMOVE, 64'h10210, 64'h10);
    send_op(OP_ADD_DIRECT, 64'h90000, 64'h10, 4'h5, 32'h5, 1'b0, 64'h123);
    send_op(OP_LOOKUP, 64'h10220, 64'd0);
    send_op(OP_LOOKUP, 64'h10000 + NREG * 64'h100, 64'd0);
    send_op(OP_REMOVE, 64'd0, AMASK);
    wait_drain();
  endtask

  task automatic test_random_mix(int n);
    req_t r;
    int sel;
    bit dense;
    dense = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) dense = $urandom_range(1, 0);
      // the sender waits for every result once midway
      if (k == n / 2) wait_drain();
      sel = $urandom_range(99, 0);
      r.opcode = (sel < 28) ? OP_ADD : (sel < 43) ? OP_ADD_DIRECT :
                 (sel < 58) ? OP_REMOVE : (sel < 78) ? OP_LOOKUP :
                 (sel < 88) ? OP_OVERLAP : (sel < 97) ? OP_PROTECT :
                 ($urandom_range(1, 0) ? OP_RSVD6 : OP_RSVD7);
      sel = $urandom_range(19, 0);
      if (sel == 0) begin
        r.addr = rand_wide();
        r.length = rand_wide();
      end else if (sel == 1) begin
        r.addr = AddrW'(AMASK - $urandom_range(4095, 0));
        r.length = AddrW'($urandom_range(8191, 0));
      end else begin
        r.addr = AddrW'($urandom_range(dense ? 'h1FFF : 'h7FFF, 0));
        r.length = AddrW'($urandom_range(dense ? 'h60 : 'h800, 0));
      end
      r.prot = 4'($urandom());
      r.sce_prot = $urandom();
      r.reserved_flag = 1'($urandom());
      r.phys_offset = ($urandom_range(3, 0) == 0) ? rand_wide() : AddrW'($urandom());
      send_item(r);
    end
    wait_drain();
  endtask

  // compare one field of a result
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t exp_r, act_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      act_r = rsp_ch.data;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected result, expected none actual %h", $time, act_r);
      end else begin
        exp_r = expected_rsp.pop_front();
        check_field("status", exp_r.status, act_r.status);
        check_field("found", exp_r.found, act_r.found);
        check_field("region_start", exp_r.region_start, act_r.region_start);
        check_field("region_length", exp_r.region_length, act_r.region_length);
        check_field("region_prot", exp_r.region_prot, act_r.region_prot);
        check_field("region_sce_prot", exp_r.region_sce_prot, act_r.region_sce_prot);
        check_field("region_reserved", exp_r.region_reserved, act_r.region_reserved);
        check_field("region_has_phys", exp_r.region_has_phys, act_r.region_has_phys);
        check_field("region_phys", exp_r.region_phys, act_r.region_phys);
      end
    end
  end

  // receiver stalls, in one of three randomly chosen patterns
  always @(negedge clk) begin
    logic rdy;
    if (cycles % 400 == 0) rx_mode = $urandom_range(2, 0);
    if (rx_stall > 0) begin
      rx_stall--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (rx_mode == 1 && $urandom_range(3, 0) == 0) rx_stall = $urandom_range(4, 1);
      if (rx_mode == 2 && $urandom_range(1, 0) == 0) rx_stall = $urandom_range(20, 1);
      if (rx_stall > 0) rdy = 1'b0;
    end
    rsp_ch.ready <= rdy;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tbl_count = 0;
    for (int i = 0; i < NREG; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_phys[i] = '0;
      tbl_prot[i] = '0;
      tbl_sce[i] = '0;
      tbl_flags[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_table_full();
    test_random_mix(600);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
